### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/taa_pkg.sv
package taa_pkg;

  localparam int PIXEL_COUNT_DEF = 2097152;
  localparam int SUM_WIDTH_DEF   = 24;

  localparam int OP_W      = 3;
  localparam int INDEX_W   = 21;
  localparam int SAMPLE_W  = 16;
  localparam int SCALE_W   = 17;
  localparam int FRAC_W    = 16;

  localparam logic [SCALE_W-1:0] FRAME_SCALE_RESET = 17'd32768;

  // APB register map: one register, word aligned.
  localparam int REG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_IDX_FRAME_SCALE = 1'b0;

  // Output queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD_RAW         = 3'd0,
    OP_SCALED_PLUS_SUM = 3'd1,
    OP_SCALE_BOTH      = 3'd2,
    OP_ADD_SCALED      = 3'd3,
    OP_SUB_SCALED      = 3'd4
  } op_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] result_red;
    logic [SAMPLE_W-1:0] result_green;
    logic [SAMPLE_W-1:0] result_blue;
    logic                clipped;
  } result_t;

endpackage

### rtl/taa_if.sv
interface taa_in_if;
  logic                           valid;
  logic                           ready;
  logic [taa_pkg::OP_W-1:0]       operation;
  logic [taa_pkg::INDEX_W-1:0]    pixel_index;
  logic [taa_pkg::SAMPLE_W-1:0]   sample_red;
  logic [taa_pkg::SAMPLE_W-1:0]   sample_green;
  logic [taa_pkg::SAMPLE_W-1:0]   sample_blue;

  modport source (output valid, operation, pixel_index, sample_red, sample_green,
                  sample_blue, input ready);
  modport sink   (input valid, operation, pixel_index, sample_red, sample_green,
                  sample_blue, output ready);
endinterface

interface taa_out_if;
  logic                           valid;
  logic                           ready;
  logic [taa_pkg::SAMPLE_W-1:0]   result_red;
  logic [taa_pkg::SAMPLE_W-1:0]   result_green;
  logic [taa_pkg::SAMPLE_W-1:0]   result_blue;
  logic                           clipped;

  modport source (output valid, result_red, result_green, result_blue, clipped,
                  input ready);
  modport sink   (input valid, result_red, result_green, result_blue, clipped,
                  output ready);
endinterface

### rtl/taa_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
module taa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/taa_lane.sv
// One color channel: products in the first stage, rounding, update and
// saturation in the second. The second stage output is combinational.
module taa_lane #(
  parameter int SUM_WIDTH = taa_pkg::SUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  taa_pkg::op_t                  op,
  input  logic [taa_pkg::SAMPLE_W-1:0]  sample,
  input  logic [SUM_WIDTH-1:0]          acc,
  input  logic [taa_pkg::SCALE_W-1:0]   scale,
  output logic [SUM_WIDTH-1:0]          new_sum,
  output logic [taa_pkg::SAMPLE_W-1:0]  result,
  output logic                          clip
);

  localparam int MIX_W  = SUM_WIDTH + 1;
  localparam int PA_W   = MIX_W + taa_pkg::SCALE_W;
  localparam int PB_W   = SUM_WIDTH + taa_pkg::SCALE_W;
  localparam int WIDE_W = SUM_WIDTH + 19;

  localparam logic [WIDE_W-1:0] ROUND_W   = WIDE_W'(1) << (taa_pkg::FRAC_W - 1);
  localparam logic [WIDE_W-1:0] SUM_MAX_W = WIDE_W'({SUM_WIDTH{1'b1}});
  localparam logic [WIDE_W-1:0] OUT_MAX_W = WIDE_W'({taa_pkg::SAMPLE_W{1'b1}});

  logic [MIX_W-1:0] mix;
  logic [MIX_W-1:0] mul_a_opnd;
  logic [PA_W-1:0]  prod_a_next;
  logic [PB_W-1:0]  prod_b_next;

  // Stage two registers.
  taa_pkg::op_t                 op2;
  logic [SUM_WIDTH-1:0]         sum2;
  logic [taa_pkg::SAMPLE_W-1:0] smp2;
  logic [PA_W-1:0]              prod_a;
  logic [PB_W-1:0]              prod_b;

  logic [WIDE_W-1:0] round_a;
  logic [WIDE_W-1:0] round_b;
  logic [WIDE_W-1:0] sum_w;
  logic [WIDE_W-1:0] smp_w;
  logic [WIDE_W-1:0] total;
  logic [WIDE_W-1:0] sum_out;
  logic              pixel_op;

  // Operation two scales sample plus sum; everything else scales the sample.
  assign mix         = MIX_W'(acc) + MIX_W'(sample);
  assign mul_a_opnd  = (op == taa_pkg::OP_SCALE_BOTH) ? mix : MIX_W'(sample);
  assign prod_a_next = PA_W'(mul_a_opnd) * PA_W'(scale);
  assign prod_b_next = PB_W'(acc) * PB_W'(scale);

  always_ff @(posedge clk) begin
    op2    <= op;
    sum2   <= acc;
    smp2   <= sample;
    prod_a <= prod_a_next;
    prod_b <= prod_b_next;
  end

  assign round_a = (WIDE_W'(prod_a) + ROUND_W) >> taa_pkg::FRAC_W;
  assign round_b = (WIDE_W'(prod_b) + ROUND_W) >> taa_pkg::FRAC_W;
  assign sum_w   = WIDE_W'(sum2);
  assign smp_w   = WIDE_W'(smp2);

  always_comb begin
    total    = '0;
    sum_out  = sum_w;
    clip     = 1'b0;
    pixel_op = 1'b0;
    result   = '0;
    case (op2)
      taa_pkg::OP_ADD_RAW: begin
        total = sum_w + smp_w;
        if (total > SUM_MAX_W) begin
          sum_out = SUM_MAX_W;
          clip    = 1'b1;
        end else begin
          sum_out = total;
        end
      end
      taa_pkg::OP_SCALED_PLUS_SUM: begin
        pixel_op = 1'b1;
        total    = round_a + sum_w;
        if (total > OUT_MAX_W) begin
          result = '1;
          clip   = 1'b1;
        end else begin
          result = total[taa_pkg::SAMPLE_W-1:0];
        end
      end
      taa_pkg::OP_SCALE_BOTH: begin
        pixel_op = 1'b1;
        if (round_a > OUT_MAX_W) begin
          result = '1;
          clip   = 1'b1;
        end else begin
          result = round_a[taa_pkg::SAMPLE_W-1:0];
        end
        if (round_b > SUM_MAX_W) begin
          sum_out = SUM_MAX_W;
          clip    = 1'b1;
        end else begin
          sum_out = round_b;
        end
      end
      taa_pkg::OP_ADD_SCALED: begin
        total = sum_w + round_a;
        if (total > SUM_MAX_W) begin
          sum_out = SUM_MAX_W;
          clip    = 1'b1;
        end else begin
          sum_out = total;
        end
      end
      taa_pkg::OP_SUB_SCALED: begin
        if (round_a > sum_w) begin
          sum_out = '0;
          clip    = 1'b1;
        end else begin
          sum_out = sum_w - round_a;
        end
      end
      default: begin
        sum_out = sum_w;
      end
    endcase
    // Accumulator reports are capped at full scale without flagging a clip.
    if (!pixel_op) begin
      result = (sum_out > OUT_MAX_W) ? '1 : sum_out[taa_pkg::SAMPLE_W-1:0];
    end
  end

  assign new_sum = sum_out[SUM_WIDTH-1:0];

endmodule

### rtl/temporal_average_accumulator.sv
// Channel      Role        Width                  Transfer condition
// pixel_in     sink        3+21+3x16 payload      valid && ready at rising clk
// pixel_out    source      3x16+1 payload         valid && ready at rising clk
// APB          register    3-bit paddr, 32 data   psel && penable && pwrite
//
// One item is taken per cycle while ready is high. A result passes the RAM
// read, the product stage and the update stage, and enters the four-entry
// output queue as the update stage completes, from which it can then be taken.
// When an item names the same in-range pixel as the item accepted just
// before it, ready drops for one cycle so the write-back can be forwarded.
// Reset clears control and sets frame_scale; the sum store is not cleared.
// Ready is low during reset and also drops while the queue plus items in
// flight would exceed four.
module temporal_average_accumulator #(
  parameter int PIXEL_COUNT = taa_pkg::PIXEL_COUNT_DEF,
  parameter int SUM_WIDTH   = taa_pkg::SUM_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  taa_in_if.sink                            pixel_in,
  taa_out_if.source                         pixel_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [taa_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [taa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [taa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

`include "assert_macros.svh"

  localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int LANES   = 3;
  localparam int WORD_W  = LANES * SUM_WIDTH;
  localparam int DEPTH_W = taa_pkg::FIFO_CNT_W + 1;

  localparam logic [taa_pkg::FIFO_CNT_W-1:0] QUEUE_FULL =
    taa_pkg::FIFO_CNT_W'(taa_pkg::FIFO_DEPTH);
  localparam logic [DEPTH_W-1:0] QUEUE_ROOM = DEPTH_W'(taa_pkg::FIFO_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration: a single register, frame_scale, at byte offset zero.
  // ---------------------------------------------------------------------
  logic [taa_pkg::SCALE_W-1:0] frame_scale;
  logic                        cfg_write;
  logic [0:0]                  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[taa_pkg::REG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_scale <= taa_pkg::FRAME_SCALE_RESET;
    end else if (cfg_write && cfg_index == taa_pkg::REG_IDX_FRAME_SCALE) begin
      frame_scale <= pwdata[taa_pkg::SCALE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_index == taa_pkg::REG_IDX_FRAME_SCALE) begin
      prdata = taa_pkg::APB_DATA_W'(frame_scale);
    end
  end

  // ---------------------------------------------------------------------
  // Input side. The pipeline never stalls; admission is limited so that
  // every item already in flight has a slot in the output queue.
  // ---------------------------------------------------------------------
  logic               in_fire;
  logic               in_ok;
  logic [ADDR_W-1:0]  in_addr;
  logic [DEPTH_W-1:0] in_flight;
  logic               room;
  logic               hazard;

  // Stage one: RAM data valid.
  logic                          v1;
  taa_pkg::op_t                  s1_op;
  logic [ADDR_W-1:0]             s1_addr;
  logic                          s1_ok;
  logic [taa_pkg::SAMPLE_W-1:0]  s1_sample [LANES];

  // Stage two: update in progress, written back at the end of the cycle.
  logic               v2;
  logic [ADDR_W-1:0]  s2_addr;
  logic               s2_ok;

  // Copy of the last write-back, for the read that raced it.
  logic               wb_valid;
  logic [ADDR_W-1:0]  wb_addr;
  logic [WORD_W-1:0]  wb_data;

  // Output queue state.
  logic [taa_pkg::FIFO_CNT_W-1:0] count;
  logic [taa_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [taa_pkg::FIFO_PTR_W-1:0] rd_ptr;
  taa_pkg::result_t               fifo_mem [taa_pkg::FIFO_DEPTH];
  taa_pkg::result_t               fifo_head;
  taa_pkg::result_t               s2_result;
  logic                           pop;

  assign in_ok   = 32'(pixel_in.pixel_index) < 32'(PIXEL_COUNT);
  assign in_addr = ADDR_W'(pixel_in.pixel_index);

  // Slots are counted against the worst case: nothing drains before landing.
  assign in_flight = DEPTH_W'(count) + DEPTH_W'(v1) + DEPTH_W'(v2);
  assign room      = in_flight < QUEUE_ROOM;

  // The item one stage ahead writes after this read, so hold this item off.
  assign hazard = v1 && s1_ok && in_ok && (s1_addr == in_addr);

  assign pixel_in.ready = !rst && room && !hazard;
  assign in_fire        = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      v1       <= in_fire;
      v2       <= v1;
      wb_valid <= v2 && s2_ok;
    end
  end

  always_ff @(posedge clk) begin
    s1_op        <= taa_pkg::op_t'(pixel_in.operation);
    s1_addr      <= in_addr;
    s1_ok        <= in_ok;
    s1_sample[0] <= pixel_in.sample_red;
    s1_sample[1] <= pixel_in.sample_green;
    s1_sample[2] <= pixel_in.sample_blue;
    s2_addr      <= s1_addr;
    s2_ok        <= s1_ok;
    wb_addr      <= s2_addr;
  end

  // ---------------------------------------------------------------------
  // Sum store: three channels packed in one word, red in the low bits.
  // ---------------------------------------------------------------------
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              fwd;

  assign ram_we = v2 && s2_ok;

  taa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PIXEL_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    wb_data <= ram_wdata;
  end

  // The read issued at the same edge as a write to that entry saw old data.
  assign fwd = wb_valid && (wb_addr == s1_addr);

  // ---------------------------------------------------------------------
  // Channel datapaths.
  // ---------------------------------------------------------------------
  logic [SUM_WIDTH-1:0]         lane_acc    [LANES];
  logic [SUM_WIDTH-1:0]         lane_sum    [LANES];
  logic [taa_pkg::SAMPLE_W-1:0] lane_result [LANES];
  logic [LANES-1:0]             lane_clip;

  for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
    // Out-of-range pixels compute against an empty accumulator.
    assign lane_acc[ch] = !s1_ok ? '0 :
                          fwd    ? wb_data[ch*SUM_WIDTH +: SUM_WIDTH] :
                                   ram_rdata[ch*SUM_WIDTH +: SUM_WIDTH];

    assign ram_wdata[ch*SUM_WIDTH +: SUM_WIDTH] = lane_sum[ch];

    taa_lane #(
      .SUM_WIDTH (SUM_WIDTH)
    ) u_lane (
      .clk     (clk),
      .op      (s1_op),
      .sample  (s1_sample[ch]),
      .acc     (lane_acc[ch]),
      .scale   (frame_scale),
      .new_sum (lane_sum[ch]),
      .result  (lane_result[ch]),
      .clip    (lane_clip[ch])
    );
  end

  assign s2_result.result_red   = lane_result[0];
  assign s2_result.result_green = lane_result[1];
  assign s2_result.result_blue  = lane_result[2];
  assign s2_result.clipped      = |lane_clip;

  // ---------------------------------------------------------------------
  // Output queue. Each finished item is pushed as stage two completes.
  // ---------------------------------------------------------------------
  assign pop       = pixel_out.valid && pixel_out.ready;
  assign fifo_head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (v2) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + taa_pkg::FIFO_CNT_W'(v2) - taa_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      fifo_mem[wr_ptr] <= s2_result;
    end
  end

  assign pixel_out.valid        = (count != '0);
  assign pixel_out.result_red   = fifo_head.result_red;
  assign pixel_out.result_green = fifo_head.result_green;
  assign pixel_out.result_blue  = fifo_head.result_blue;
  assign pixel_out.clipped      = fifo_head.clipped;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  logic adjacent_same;

  assign adjacent_same = v1 && v2 && s1_ok && s2_ok && (s1_addr == s2_addr);

  `ASSERT_ALWAYS(a_queue_no_overflow, !(v2 && !pop && count == QUEUE_FULL), "queue overflow")
  `ASSERT_ALWAYS(a_in_flight_bound, in_flight <= QUEUE_ROOM, "items in flight exceed room")
  `ASSERT_ALWAYS(a_no_adjacent_same_pixel, !adjacent_same, "adjacent items share a pixel")
  `ASSERT_NEXT(a_transfer_enters_pipe, in_fire, v1, "accepted item missing from stage one")

endmodule

### tb/temporal_average_accumulator_tb.sv
module temporal_average_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and run limits. The slowest legal run is set by its traffic:
  // under nine hundred transfers, each stretched by sender gaps, sink stalls
  // and same-pixel bubbles, plus two long sink hold-offs and the register
  // updates between phases. The watchdog sits far above that.
  localparam int CLK_PERIOD      = 20;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 6;
  localparam int TAIL_CYCLES     = 8;

  localparam int SUM_W = taa_pkg::SUM_WIDTH_DEF;
  localparam longint unsigned SUM_TOP = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned OUT_TOP = (64'd1 << taa_pkg::SAMPLE_W) - 64'd1;

  // Operation codes the block does not define; it must leave the store alone.
  localparam logic [taa_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [taa_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [taa_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [taa_pkg::REG_ADDR_W-1:0] FRAME_SCALE_ADDR =
    taa_pkg::REG_ADDR_W'(4 * taa_pkg::REG_IDX_FRAME_SCALE);
  localparam logic [taa_pkg::SCALE_W-1:0] SCALE_MIN      = 17'd256;
  localparam logic [taa_pkg::SCALE_W-1:0] SCALE_UNITY    = 17'd65536;
  localparam logic [taa_pkg::SCALE_W-1:0] SCALE_OVER_ONE = 17'h1FFFF;

  typedef logic [taa_pkg::INDEX_W-1:0] idx_t;
  localparam idx_t PIX_FIRST = '0;
  localparam idx_t PIX_LAST  = idx_t'(taa_pkg::PIXEL_COUNT_DEF - 1);
  localparam idx_t PIX_ODD   = 21'h0AAAAA;
  localparam idx_t PIX_EVEN  = 21'h155555;

  typedef struct packed {
    logic [taa_pkg::OP_W-1:0]     op;
    idx_t                         idx;
    logic [taa_pkg::SAMPLE_W-1:0] red;
    logic [taa_pkg::SAMPLE_W-1:0] green;
    logic [taa_pkg::SAMPLE_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    bit [SUM_W-1:0] red;
    bit [SUM_W-1:0] green;
    bit [SUM_W-1:0] blue;
  } sums_t;

  typedef struct packed {
    pixel_t           px;
    bit               typed;
    taa_pkg::result_t want;
  } directed_row_t;

  localparam taa_pkg::result_t NO_RESULT = '0;

  // Directed stimulus, run with a scale of exactly one so that scaling is
  // the identity and the typed results can be read straight off the rules.
  // Rows with typed cleared are checked against the predictor instead.
  localparam int DIRECTED_N = 20;
  directed_row_t directed_rows [DIRECTED_N] = '{
    // Fresh pixel zero: grow past 16 bits; an over-range report is not a clip.
    '{'{taa_pkg::OP_ADD_RAW, PIX_FIRST, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{'{taa_pkg::OP_ADD_RAW, PIX_FIRST, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
    '{'{taa_pkg::OP_ADD_RAW, PIX_FIRST, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
    // Computed pixels above full scale saturate and clip.
    '{'{taa_pkg::OP_SCALED_PLUS_SUM, PIX_FIRST, 16'h0000, 16'h0001, 16'hFFFF}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
    '{'{taa_pkg::OP_SCALE_BOTH, PIX_FIRST, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
    // Subtract down to exactly zero (no clip), then below zero (clip).
    '{'{taa_pkg::OP_SUB_SCALED, PIX_FIRST, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
    '{'{taa_pkg::OP_SUB_SCALED, PIX_FIRST, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{'{taa_pkg::OP_SUB_SCALED, PIX_FIRST, 16'h0001, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b1}},
    // Top pixel of the store.
    '{'{taa_pkg::OP_ADD_SCALED, PIX_LAST, 16'h1234, 16'h5678, 16'h9ABC}, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 1'b0}},
    '{'{taa_pkg::OP_SCALED_PLUS_SUM, PIX_LAST, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 1'b0}},
    '{'{taa_pkg::OP_SCALE_BOTH, PIX_LAST, 16'h0001, 16'h0001, 16'h0001}, 1'b1,
      '{16'h1235, 16'h5679, 16'h9ABD, 1'b0}},
    // Undefined codes only report the running sum.
    '{'{OP_SPARE_FIRST, PIX_LAST, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 1'b0}},
    '{'{OP_SPARE_MID, PIX_LAST, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 1'b0}},
    '{'{OP_SPARE_LAST, PIX_LAST, 16'h8001, 16'h7FFE, 16'h5A5A}, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 1'b0}},
    // Alternating bit patterns on index and samples.
    '{'{taa_pkg::OP_ADD_RAW, PIX_ODD, 16'hAAAA, 16'h5555, 16'h8001}, 1'b0, NO_RESULT},
    '{'{taa_pkg::OP_ADD_RAW, PIX_EVEN, 16'h5555, 16'hAAAA, 16'h7FFE}, 1'b0, NO_RESULT},
    '{'{taa_pkg::OP_SCALED_PLUS_SUM, PIX_ODD, 16'h8000, 16'h0001, 16'hFFFF}, 1'b0,
      NO_RESULT},
    '{'{taa_pkg::OP_ADD_SCALED, PIX_ODD, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RESULT},
    '{'{taa_pkg::OP_SCALE_BOTH, PIX_EVEN, 16'h7FFF, 16'h8000, 16'h0000}, 1'b0, NO_RESULT},
    '{'{taa_pkg::OP_SUB_SCALED, PIX_EVEN, 16'h0100, 16'hFFFF, 16'h0001}, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [taa_pkg::REG_ADDR_W-1:0] paddr;
  logic [taa_pkg::APB_DATA_W-1:0] pwdata;
  logic [taa_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  taa_in_if  pix_in ();
  taa_out_if pix_out ();

  temporal_average_accumulator DUT (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_in),
    .pixel_out (pix_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: its own copy of the frame scale and of every running
  // sum touched so far. An entry not yet touched is taken as zero.
  logic [taa_pkg::SCALE_W-1:0] scale_now = taa_pkg::FRAME_SCALE_RESET;
  sums_t                       sum_store [idx_t];
  taa_pkg::result_t            awaited_results [$];

  // Traffic shaping shared by the sender and the sink process.
  bit calm          = 1'b0;
  int hold_off_asks = 0;

  int   mismatches      = 0;
  int   cycle_count     = 0;
  int   pixels_sent     = 0;
  int   results_checked = 0;
  int   clipped_results = 0;
  int   same_pixel_runs = 0;
  int   scale_settings  = 0;
  int   readbacks       = 0;
  bit   have_last_idx   = 1'b0;
  idx_t last_idx;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  function automatic longint unsigned scaled(input longint unsigned x);
    return (x * longint'(scale_now) + 64'd32768) >> taa_pkg::FRAC_W;
  endfunction

  function automatic longint unsigned limit(input longint unsigned x,
                                           input longint unsigned top,
                                           inout bit clip);
    if (x > top) begin
      clip = 1'b1;
      return top;
    end
    return x;
  endfunction

  // One colour channel of one pixel: updates the running sum in acc and
  // returns what the block reports on that channel.
  function automatic logic [taa_pkg::SAMPLE_W-1:0] blend_channel(
      input logic [taa_pkg::OP_W-1:0] op,
      input longint unsigned sample,
      inout longint unsigned acc,
      inout bit clip);
    longint unsigned s;
    longint unsigned t;
    s = acc & SUM_TOP;
    case (op)
      taa_pkg::OP_ADD_RAW: s = limit(s + sample, SUM_TOP, clip);
      taa_pkg::OP_SCALED_PLUS_SUM: begin
        acc = s;
        return taa_pkg::SAMPLE_W'(limit(scaled(sample) + s, OUT_TOP, clip));
      end
      taa_pkg::OP_SCALE_BOTH: begin
        t = limit(scaled(sample + s), OUT_TOP, clip);
        acc = limit(scaled(s), SUM_TOP, clip);
        return taa_pkg::SAMPLE_W'(t);
      end
      taa_pkg::OP_ADD_SCALED: s = limit(s + scaled(sample), SUM_TOP, clip);
      taa_pkg::OP_SUB_SCALED: begin
        t = scaled(sample);
        if (t > s) begin
          clip = 1'b1;
          s = 0;
        end else begin
          s = s - t;
        end
      end
      default: ;
    endcase
    acc = s;
    return taa_pkg::SAMPLE_W'((s > OUT_TOP) ? OUT_TOP : s);
  endfunction

  // Applies one accepted pixel to the predicted store and returns the
  // result the block owes for it.
  function automatic taa_pkg::result_t accumulate_pixel(input pixel_t px);
    sums_t            entry;
    longint unsigned  r;
    longint unsigned  g;
    longint unsigned  b;
    bit               clip;
    bit               in_store;
    taa_pkg::result_t res;
    in_store = (px.idx < taa_pkg::PIXEL_COUNT_DEF);
    entry = '0;
    if (in_store && sum_store.exists(px.idx))
      entry = sum_store[px.idx];
    r = entry.red;
    g = entry.green;
    b = entry.blue;
    clip = 1'b0;
    res.result_red   = blend_channel(px.op, px.red, r, clip);
    res.result_green = blend_channel(px.op, px.green, g, clip);
    res.result_blue  = blend_channel(px.op, px.blue, b, clip);
    res.clipped      = clip;
    if (in_store) begin
      entry.red   = r[SUM_W-1:0];
      entry.green = g[SUM_W-1:0];
      entry.blue  = b[SUM_W-1:0];
      sum_store[px.idx] = entry;
    end
    return res;
  endfunction

  function automatic logic [taa_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return taa_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offers one pixel, holding valid until the transfer happens, then records
  // what the block owes for it. A typed expectation replaces the predicted
  // one, but the predictor still runs so that its store stays in step.
  task automatic send_pixel(input pixel_t px, input bit typed,
                            input taa_pkg::result_t typed_want);
    taa_pkg::result_t want;
    while (!calm && $urandom_range(99) < 35) begin
      @(negedge clk);
      pix_in.valid <= 1'b0;
    end
    @(negedge clk);
    pix_in.valid        <= 1'b1;
    pix_in.operation    <= px.op;
    pix_in.pixel_index  <= px.idx;
    pix_in.sample_red   <= px.red;
    pix_in.sample_green <= px.green;
    pix_in.sample_blue  <= px.blue;
    do @(posedge clk); while (!pix_in.ready);
    want = accumulate_pixel(px);
    if (typed)
      want = typed_want;
    awaited_results.push_back(want);
    if (have_last_idx && last_idx == px.idx)
      same_pixel_runs++;
    last_idx = px.idx;
    have_last_idx = 1'b1;
    pixels_sent++;
  endtask

  // Stops offering pixels and waits until every owed result has come out.
  task automatic drain_results();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [taa_pkg::REG_ADDR_W-1:0] addr,
                           input logic [taa_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [taa_pkg::REG_ADDR_W-1:0] addr,
                          output logic [taa_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_scale_readback(input logic [taa_pkg::SCALE_W-1:0] want);
    logic [taa_pkg::APB_DATA_W-1:0] got;
    apb_read(FRAME_SCALE_ADDR, got);
    readbacks++;
    if (got !== taa_pkg::APB_DATA_W'(want))
      flag_mismatch($sformatf("frame_scale reads %h, want %h", got, want));
  endtask

  // The scale may only change while the block is empty: drain, let the
  // pipeline settle, write, and read the register back.
  task automatic set_scale(input logic [taa_pkg::SCALE_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(FRAME_SCALE_ADDR, taa_pkg::APB_DATA_W'(value));
    scale_now = value;
    scale_settings++;
    check_scale_readback(value);
  endtask

  // One phase of random traffic over a small pool of pixels, so that sums
  // build up, saturate and floor, and the same pixel often arrives twice
  // in a row. A few undefined codes are mixed in.
  task automatic run_phase(input int n_items, input int pool_size, input bit relaxed,
                           input bit ask_hold, input bit pause_mid);
    idx_t   pool [$];
    pixel_t px;
    calm = relaxed;
    for (int k = 0; k < pool_size; k++) begin
      case ($urandom_range(5))
        0: pool.push_back(PIX_FIRST);
        1: pool.push_back(PIX_LAST);
        default: pool.push_back(idx_t'($urandom));
      endcase
    end
    for (int i = 0; i < n_items; i++) begin
      if (ask_hold && i == n_items / 3)
        hold_off_asks++;
      if (pause_mid && i == (2 * n_items) / 3)
        drain_results();
      if ($urandom_range(99) < 6)
        px.op = taa_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      else
        px.op = taa_pkg::OP_W'($urandom_range(taa_pkg::OP_SUB_SCALED,
                                              taa_pkg::OP_ADD_RAW));
      px.idx   = pool[$urandom_range(pool.size() - 1)];
      px.red   = rand_sample();
      px.green = rand_sample();
      px.blue  = rand_sample();
      send_pixel(px, 1'b0, NO_RESULT);
    end
    calm = 1'b0;
  endtask

  // Result sink. It stalls at random about a third of the time, never in
  // calm phases, and on request goes quiet for a long stretch so that the
  // block's queue fills and it has to push back on its input.
  initial begin : result_sink
    int quiet_left;
    int asks_served;
    quiet_left  = 0;
    asks_served = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (asks_served != hold_off_asks) begin
        asks_served = hold_off_asks;
        quiet_left  = HOLD_OFF_CYCLES;
      end
      if (quiet_left > 0) begin
        quiet_left--;
        pix_out.ready <= 1'b0;
      end else if (calm || rst) begin
        pix_out.ready <= 1'b1;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Every result transfer is checked against the oldest owed result.
  always @(posedge clk) begin : result_check
    taa_pkg::result_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result transfer with nothing owed");
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (want.clipped)
          clipped_results++;
        if (pix_out.result_red !== want.result_red)
          flag_mismatch($sformatf("result %0d red %h, want %h", results_checked,
                                  pix_out.result_red, want.result_red));
        if (pix_out.result_green !== want.result_green)
          flag_mismatch($sformatf("result %0d green %h, want %h", results_checked,
                                  pix_out.result_green, want.result_green));
        if (pix_out.result_blue !== want.result_blue)
          flag_mismatch($sformatf("result %0d blue %h, want %h", results_checked,
                                  pix_out.result_blue, want.result_blue));
        if (pix_out.clipped !== want.clipped)
          flag_mismatch($sformatf("result %0d clipped %b, want %b", results_checked,
                                  pix_out.clipped, want.clipped));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with %0d results owed.",
               cycle_count, awaited_results.size());
      $display("temporal_average_accumulator: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pix_in.valid        = 1'b0;
    pix_in.operation    = '0;
    pix_in.pixel_index  = '0;
    pix_in.sample_red   = '0;
    pix_in.sample_green = '0;
    pix_in.sample_blue  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // The register must come out of reset at half scale.
    check_scale_readback(taa_pkg::FRAME_SCALE_RESET);

    // Directed rows at a scale of exactly one.
    set_scale(SCALE_UNITY);
    for (int i = 0; i < DIRECTED_N; i++)
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);

    // Random phases: the reset value written back with a long sink hold-off,
    // the smallest scale with no idling on either side, a scale above one
    // where sums double and saturate (with a full pause mid-phase), unity
    // with a long sink hold-off, then three random scales and pool sizes.
    set_scale(taa_pkg::FRAME_SCALE_RESET);
    run_phase(130, 6, 1'b0, 1'b1, 1'b0);
    set_scale(SCALE_MIN);
    run_phase(120, 3, 1'b1, 1'b0, 1'b0);
    set_scale(SCALE_OVER_ONE);
    run_phase(120, 1, 1'b0, 1'b0, 1'b1);
    set_scale(SCALE_UNITY);
    run_phase(120, 8, 1'b0, 1'b1, 1'b0);
    repeat (3) begin
      set_scale(taa_pkg::SCALE_W'($urandom_range(SCALE_UNITY, SCALE_MIN)));
      run_phase(120, $urandom_range(12, 1), 1'b0, 1'b0, 1'b0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (%0d back to back on the same pixel) over %0d scale settings.",
             pixels_sent, same_pixel_runs, scale_settings);
    $display("Checked %0d results, %0d of them clipped, and %0d register readbacks.",
             results_checked, clipped_results, readbacks);
    if (mismatches == 0)
      $display("temporal_average_accumulator: match");
    else
      $display("temporal_average_accumulator: mismatch");
    $finish;
  end

endmodule
